>>> rtl/ise_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_pkg: shared types and codes for the indexed sequence engine
// Action codes, result status codes and the per-cell operation that the
// controller broadcasts along the chain of storage cells.
// ----------------------------------------------------------------------------
package ise_pkg;

	// Fixed widths of the transaction fields
	localparam int ACTION_W   = 3;
	localparam int POSITION_W = 6;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 32;
	localparam int LENGTH_W   = 7;
	localparam int STATUS_W   = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND       = 3'd0,
		ACT_REMOVE_LAST  = 3'd1,
		ACT_REMOVE_FIRST = 3'd2,
		ACT_INSERT       = 3'd3,
		ACT_OVERWRITE    = 3'd4,
		ACT_READ         = 3'd5,
		ACT_REMOVE_AT    = 3'd6
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// What every cell does in one cycle, judged against the broadcast index
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2,
		CELL_WRITE  = 2'd3
	} cell_op_t;

endpackage

>>> rtl/ise_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_cell: one storage cell of the sequence chain
// Holds one data word. Each cycle it holds, takes the word of its lower
// neighbor (insert), takes the word of its upper neighbor (remove) or loads
// the broadcast word, depending on its own index against the broadcast one.
// ----------------------------------------------------------------------------
module ise_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int IDX_W      = 6,
	parameter int CELL_IDX   = 0
) (
	input  logic                  clk,
	input  ise_pkg::cell_op_t     op,
	input  logic [IDX_W-1:0]      index,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic [DATA_WIDTH-1:0] lower,
	input  logic [DATA_WIDTH-1:0] upper,
	output logic [DATA_WIDTH-1:0] q
);
	import ise_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic                  at_k;
	logic                  above_k;
	logic [DATA_WIDTH-1:0] word_nxt;
	logic [DATA_WIDTH-1:0] word_q;

	assign at_k    = (index == MY_IDX);
	assign above_k = (MY_IDX > index);

	// Pick the next word from self, neighbor or broadcast
	always_comb begin
		unique case (op)
			CELL_HOLD:   word_nxt = word_q;
			CELL_INSERT: word_nxt = above_k ? lower : (at_k ? word : word_q);
			CELL_REMOVE: word_nxt = (above_k || at_k) ? upper : word_q;
			CELL_WRITE:  word_nxt = at_k ? word : word_q;
		endcase
	end

	// Store the word
	always_ff @(posedge clk) begin
		word_q <= word_nxt;
	end

	assign q = word_q;

endmodule

>>> rtl/indexed_sequence_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_engine: bounded ordered sequence of data words
// Append, remove last/first, insert before/after, overwrite, read and
// remove at an index, one transaction per cycle, on a chain of cells.
// ----------------------------------------------------------------------------
// The block takes one transaction in every clock cycle: busy stays low, and
// the result of a transaction accepted at one edge is on status, data_out
// and length_now, marked by done, from the next cycle until the next result;
// the receiver cannot stall it, so it must take each result as it appears. The
// words sit in a row of CAPACITY cells that all shift, load or hold in the
// same cycle as the length register updates; the longest path is the index
// decode plus the CAPACITY-to-one select that picks the word read or removed.
// No clearing pass follows reset: entries beyond the length are never read.
// ----------------------------------------------------------------------------
module indexed_sequence_engine #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [ise_pkg::ACTION_W-1:0]       action,
	input  logic [ise_pkg::POSITION_W-1:0]     position,
	input  logic                               place_after,
	input  logic [ise_pkg::IN_DATA_W-1:0]      data_in,
	output logic                               done,
	output logic [ise_pkg::STATUS_W-1:0]       status,
	output logic [ise_pkg::OUT_DATA_W-1:0]     data_out,
	output logic [ise_pkg::LENGTH_W-1:0]       length_now
);
	import ise_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POSITION_W + 1) ? CNT_W : POSITION_W + 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic                  done_q;
	status_t               status_q;
	logic [OUT_DATA_W-1:0] data_out_q;

	logic [CMP_W-1:0]      pos_x;
	logic [CMP_W-1:0]      cnt_x;
	logic [CMP_W-1:0]      ins_x;
	logic                  in_range;
	logic                  is_full;
	logic                  is_empty;
	cell_op_t              op;
	logic [IDX_W-1:0]      k;
	status_t               st;
	logic                  take;
	logic [DATA_WIDTH-1:0] word;
	logic [DATA_WIDTH-1:0] rd;
	logic [OUT_DATA_W-1:0] rd_ext;
	logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

	assign busy = 1'b0;

	// Fit the input word to the stored width, and the read word and the length to the ports
	generate
		if (DATA_WIDTH <= IN_DATA_W) begin : g_word_narrow
			assign word = data_in[DATA_WIDTH-1:0];
		end else begin : g_word_wide
			assign word = {{(DATA_WIDTH - IN_DATA_W){1'b0}}, data_in};
		end
		if (DATA_WIDTH >= OUT_DATA_W) begin : g_rd_wide
			assign rd_ext = rd[OUT_DATA_W-1:0];
		end else begin : g_rd_narrow
			assign rd_ext = {{(OUT_DATA_W - DATA_WIDTH){1'b0}}, rd};
		end
		if (CNT_W >= LENGTH_W) begin : g_len_wide
			assign length_now = count_q[LENGTH_W-1:0];
		end else begin : g_len_narrow
			assign length_now = {{(LENGTH_W - CNT_W){1'b0}}, count_q};
		end
	endgenerate

	// Compare the index against the length
	assign pos_x    = CMP_W'(position);
	assign cnt_x    = CMP_W'(count_q);
	assign ins_x    = pos_x + CMP_W'(place_after);
	assign in_range = (pos_x < cnt_x);
	assign is_full  = (count_q == CNT_FULL);
	assign is_empty = (count_q == '0);

	// Decode the transaction into a cell operation, index and status
	always_comb begin
		op        = CELL_HOLD;
		k         = pos_x[IDX_W-1:0];
		st        = ST_OK;
		take      = 1'b0;
		count_nxt = count_q;
		unique case (action)
			ACT_APPEND: begin
				k = count_q[IDX_W-1:0];
				if (is_full) begin
					st = ST_FULL;
				end else begin
					op        = CELL_INSERT;
					count_nxt = count_q + CNT_ONE;
				end
			end
			ACT_REMOVE_LAST: begin
				k = IDX_W'(count_q - CNT_ONE);
				if (is_empty) begin
					st = ST_RANGE;
				end else begin
					op        = CELL_REMOVE;
					take      = 1'b1;
					count_nxt = count_q - CNT_ONE;
				end
			end
			ACT_REMOVE_FIRST: begin
				k = '0;
				if (is_empty) begin
					st = ST_RANGE;
				end else begin
					op        = CELL_REMOVE;
					take      = 1'b1;
					count_nxt = count_q - CNT_ONE;
				end
			end
			ACT_INSERT: begin
				k = ins_x[IDX_W-1:0];
				if (!in_range) begin
					st = ST_RANGE;
				end else if (is_full) begin
					st = ST_FULL;
				end else begin
					op        = CELL_INSERT;
					count_nxt = count_q + CNT_ONE;
				end
			end
			ACT_OVERWRITE: begin
				if (!in_range) begin
					st = ST_RANGE;
				end else begin
					op = CELL_WRITE;
				end
			end
			ACT_READ: begin
				if (!in_range) begin
					st = ST_RANGE;
				end else begin
					take = 1'b1;
				end
			end
			ACT_REMOVE_AT: begin
				if (!in_range) begin
					st = ST_RANGE;
				end else begin
					op        = CELL_REMOVE;
					take      = 1'b1;
					count_nxt = count_q - CNT_ONE;
				end
			end
			default: begin
				st = ST_RANGE;
			end
		endcase
		if (!start) begin
			op = CELL_HOLD;
		end
	end

	// Build the chain of cells
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [DATA_WIDTH-1:0] lower;
			logic [DATA_WIDTH-1:0] upper;
			if (gi == 0) begin : g_first
				assign lower = '0;
			end else begin : g_mid_lo
				assign lower = cell_q[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign upper = cell_q[gi];
			end else begin : g_mid_hi
				assign upper = cell_q[gi+1];
			end
			ise_cell #(
				.DATA_WIDTH (DATA_WIDTH),
				.IDX_W      (IDX_W),
				.CELL_IDX   (gi)
			) u_cell (
				.clk   (clk),
				.op    (op),
				.index (k),
				.word  (word),
				.lower (lower),
				.upper (upper),
				.q     (cell_q[gi])
			);
		end
	endgenerate

	// Select the addressed word before the chain moves
	assign rd = cell_q[k];

	// Advance length and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			done_q <= start;
			if (start) begin
				count_q  <= count_nxt;
				status_q <= st;
			end
		end
	end

	// Hold the result word
	always_ff @(posedge clk) begin
		if (start) begin
			data_out_q <= take ? rd_ext : '0;
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign data_out = data_out_q;

`ifndef SYNTHESIS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> done)
		else $error("no result after accepted transaction");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("length beyond capacity");

	a_idle_length: assert property (@(posedge clk) disable iff (!arst_n)
		!start |=> $stable(count_q))
		else $error("length changed without a transaction");

	a_full_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == ST_FULL) |-> (count_q == CNT_FULL))
		else $error("full status below capacity");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q != ST_OK) |-> (data_out_q == '0))
		else $error("data returned with error status");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the indexed sequence engine
// Drives a short table of hand-picked transactions and then a long run of
// random ones that fill the sequence past capacity and drain it past empty.
// A shadow copy of the sequence predicts each result that the table does not give, which is checked
// field by field as it appears on the result ports.
// ----------------------------------------------------------------------------
module tb_top;

	import ise_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int RANDOM_ITEMS = 1250;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 4;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

	typedef struct {
		status_t              status;
		logic [OUT_DATA_W-1:0] data;
		logic [LENGTH_W-1:0]   len;
	} seq_result_t;

	typedef struct {
		logic [ACTION_W-1:0]   act;
		logic [POSITION_W-1:0] pos;
		logic                  after;
		logic [IN_DATA_W-1:0]  word;
		bit                    typed;
		seq_result_t           res;
	} stim_row_t;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [ACTION_W-1:0] action = '0;
	logic [POSITION_W-1:0] position = '0;
	logic place_after = 1'b0;
	logic [IN_DATA_W-1:0] data_in = '0;
	logic busy;
	logic done;
	logic [STATUS_W-1:0] status;
	logic [OUT_DATA_W-1:0] data_out;
	logic [LENGTH_W-1:0] length_now;

	logic [IN_DATA_W-1:0] shadow_words[$];
	seq_result_t pending_results[$];
	stim_row_t directed_rows[$];

	int fail_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int full_count = 0;
	int range_count = 0;
	int peak_len = 0;
	int idle_pct = 10;
	int stall_cycles = 0;

	indexed_sequence_engine #(
		.CAPACITY(CAPACITY),
		.DATA_WIDTH(32)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.position(position),
		.place_after(place_after),
		.data_in(data_in),
		.done(done),
		.status(status),
		.data_out(data_out),
		.length_now(length_now)
	);

	always #4 clk = ~clk;

	// Apply one transaction to the shadow sequence and return its result
	function automatic seq_result_t apply_to_sequence(logic [ACTION_W-1:0] act,
			logic [POSITION_W-1:0] pos, logic after, logic [IN_DATA_W-1:0] word);
		seq_result_t res;
		int len;
		bit hit;
		len = shadow_words.size();
		hit = int'(pos) < len;
		res.status = ST_OK;
		res.data = '0;
		case (act)
			ACT_APPEND: begin
				if (len >= CAPACITY) res.status = ST_FULL;
				else shadow_words.push_back(word);
			end
			ACT_REMOVE_LAST: begin
				if (len == 0) res.status = ST_RANGE;
				else res.data = shadow_words.pop_back();
			end
			ACT_REMOVE_FIRST: begin
				if (len == 0) res.status = ST_RANGE;
				else res.data = shadow_words.pop_front();
			end
			ACT_INSERT: begin
				if (!hit) res.status = ST_RANGE;
				else if (len >= CAPACITY) res.status = ST_FULL;
				else shadow_words.insert(after ? int'(pos) + 1 : int'(pos), word);
			end
			ACT_OVERWRITE: begin
				if (!hit) res.status = ST_RANGE;
				else shadow_words[pos] = word;
			end
			ACT_READ: begin
				if (!hit) res.status = ST_RANGE;
				else res.data = shadow_words[pos];
			end
			ACT_REMOVE_AT: begin
				if (!hit) res.status = ST_RANGE;
				else begin
					res.data = shadow_words[pos];
					shadow_words.delete(pos);
				end
			end
			default: res.status = ST_RANGE;
		endcase
		res.len = LENGTH_W'(shadow_words.size());
		return res;
	endfunction

	function automatic stim_row_t row(logic [ACTION_W-1:0] act, logic [POSITION_W-1:0] pos,
			logic after, logic [IN_DATA_W-1:0] word, bit typed,
			status_t st, logic [OUT_DATA_W-1:0] dout, logic [LENGTH_W-1:0] len);
		stim_row_t r;
		r.act = act;
		r.pos = pos;
		r.after = after;
		r.word = word;
		r.typed = typed;
		r.res.status = st;
		r.res.data = dout;
		r.res.len = len;
		return r;
	endfunction

	// Offer one transaction, hold it until accepted, then log what it should return
	task automatic send_item(stim_row_t item);
		seq_result_t predicted;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= item.act;
		position <= item.pos;
		place_after <= item.after;
		data_in <= item.word;
		do @(posedge clk); while (busy);
		predicted = apply_to_sequence(item.act, item.pos, item.after, item.word);
		pending_results.push_back(item.typed ? item.res : predicted);
		sent_count++;
		if (predicted.status == ST_FULL) full_count++;
		if (predicted.status == ST_RANGE) range_count++;
		if (int'(predicted.len) > peak_len) peak_len = int'(predicted.len);
	endtask

	// Check every result against the oldest expectation
	always @(posedge clk) begin
		seq_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d data %h length %0d",
					status, data_out, length_now);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (data_out !== want.data) begin
					$error("data_out: expected %h, got %h", want.data, data_out);
					fail_count++;
				end
				if (length_now !== want.len) begin
					$error("length_now: expected %0d, got %0d", want.len, length_now);
					fail_count++;
				end
			end
		end
	end

	// Stop the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d idle cycles", stall_cycles);
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		stim_row_t item;
		traffic_mode_t mode;
		int pick;
		int add_w;
		int rem_w;
		int len;

		// Hold reset low, then release it
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty, range, extremes and the unused code
		directed_rows.push_back(row(ACT_REMOVE_LAST, 6'd0, 1'b0, 32'h0, 1'b1, ST_RANGE, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_REMOVE_FIRST, 6'd0, 1'b0, 32'h0, 1'b1, ST_RANGE, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_INSERT, 6'd0, 1'b0, 32'h1, 1'b1, ST_RANGE, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_OVERWRITE, 6'd0, 1'b0, 32'h2, 1'b1, ST_RANGE, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_READ, 6'd0, 1'b0, 32'h0, 1'b1, ST_RANGE, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_REMOVE_AT, 6'd0, 1'b0, 32'h0, 1'b1, ST_RANGE, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_UNUSED, 6'd0, 1'b0, 32'h0, 1'b1, ST_RANGE, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_APPEND, 6'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h0, 7'd1));
		directed_rows.push_back(row(ACT_APPEND, 6'd63, 1'b1, 32'h0, 1'b1, ST_OK, 32'h0, 7'd2));
		directed_rows.push_back(row(ACT_READ, 6'd0, 1'b0, 32'h0, 1'b1, ST_OK, 32'hFFFF_FFFF, 7'd2));
		directed_rows.push_back(row(ACT_READ, 6'd63, 1'b0, 32'h0, 1'b1, ST_RANGE, 32'h0, 7'd2));
		directed_rows.push_back(row(ACT_READ, 6'd2, 1'b0, 32'h0, 1'b1, ST_RANGE, 32'h0, 7'd2));
		directed_rows.push_back(row(ACT_INSERT, 6'd1, 1'b1, 32'hA5A5_A5A5, 1'b0, ST_OK, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_INSERT, 6'd0, 1'b0, 32'h5A5A_5A5A, 1'b0, ST_OK, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_INSERT, 6'd63, 1'b1, 32'h1, 1'b1, ST_RANGE, 32'h0, 7'd4));
		directed_rows.push_back(row(ACT_OVERWRITE, 6'd3, 1'b0, 32'h1234_5678, 1'b0, ST_OK, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_READ, 6'd3, 1'b0, 32'h0, 1'b0, ST_OK, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_READ, 6'd1, 1'b0, 32'h0, 1'b0, ST_OK, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_UNUSED, 6'd63, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_RANGE, 32'h0, 7'd4));
		directed_rows.push_back(row(ACT_REMOVE_AT, 6'd1, 1'b0, 32'h0, 1'b0, ST_OK, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_REMOVE_LAST, 6'd0, 1'b0, 32'h0, 1'b0, ST_OK, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_REMOVE_FIRST, 6'd0, 1'b0, 32'h0, 1'b0, ST_OK, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_REMOVE_AT, 6'd0, 1'b0, 32'h0, 1'b0, ST_OK, 32'h0, 7'd0));
		directed_rows.push_back(row(ACT_REMOVE_LAST, 6'd0, 1'b0, 32'h0, 1'b0, ST_OK, 32'h0, 7'd0));

		foreach (directed_rows[i]) send_item(directed_rows[i]);

		// Random traffic: fill past capacity, drain past empty, with mixed stretches
		mode = MODE_FILL;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) idle_pct = 50;
			if (n == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
			len = shadow_words.size();

			// Switch traffic shape at the boundaries, now and then at random
			if (mode == MODE_FILL && len == CAPACITY && $urandom_range(0, 99) < 25)
				mode = MODE_DRAIN;
			else if (mode == MODE_DRAIN && len == 0 && $urandom_range(0, 99) < 25)
				mode = MODE_FILL;
			else if ($urandom_range(0, 99) < 2)
				mode = traffic_mode_t'($urandom_range(0, 2));

			case (mode)
				MODE_FILL: begin add_w = 70; rem_w = 15; end
				MODE_DRAIN: begin add_w = 15; rem_w = 70; end
				default: begin add_w = 40; rem_w = 40; end
			endcase

			pick = $urandom_range(0, 99);
			if (pick < 2) item.act = ACT_UNUSED;
			else if (pick < 2 + add_w)
				item.act = $urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT;
			else if (pick < 2 + add_w + rem_w) begin
				case ($urandom_range(0, 2))
					0: item.act = ACT_REMOVE_LAST;
					1: item.act = ACT_REMOVE_FIRST;
					default: item.act = ACT_REMOVE_AT;
				endcase
			end else
				item.act = $urandom_range(0, 1) ? ACT_OVERWRITE : ACT_READ;

			// Aim mostly at live entries, sometimes anywhere
			if (len > 0 && $urandom_range(0, 99) < 85)
				item.pos = POSITION_W'($urandom_range(0, len - 1));
			else
				item.pos = POSITION_W'($urandom_range(0, 63));

			pick = $urandom_range(0, 99);
			if (pick < 5) item.word = '0;
			else if (pick < 10) item.word = '1;
			else item.word = $urandom;
			item.after = 1'($urandom_range(0, 1));
			item.typed = 1'b0;
			send_item(item);
		end
		start <= 1'b0;

		// Drain outstanding results, then let the pipeline settle
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d transactions, %0d results checked, peak length %0d",
			sent_count, checked_count, peak_len);
		$display("saw %0d full and %0d empty or out-of-range rejections, %0d failures",
			full_count, range_count, fail_count);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
